/* sv/drive_distance_pid_heading_hold_core_defines.svh */
// Assertion macros for the drive distance PID core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DRIVE_DISTANCE_PID_HEADING_HOLD_CORE_DEFINES_SVH
`define DRIVE_DISTANCE_PID_HEADING_HOLD_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define DDPID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define DDPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DDPID_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDPID_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/ddpid_pkg.sv */
// Shared widths, constants and register indexes for the drive distance PID core.
// No dependencies; used by the channel interfaces and the core.
package ddpid_pkg;

  // Default parameter values.
  localparam int GAIN_FRAC_DEFAULT = 8;
  localparam int SUM_WIDTH_DEFAULT = 40;

  // Field widths.
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int HERR_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 7;
  localparam int CNT_W      = 16;
  localparam int PWR_W      = 8;
  localparam int ERR_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Scaling constants: heading in centidegrees, distance error in half ticks.
  localparam int HEADING_HALF  = 18000;
  localparam int HEADING_FULL  = 36000;
  localparam int ERROR_WINDOW  = 300;
  localparam int FINISH_MARGIN = 10;
  localparam int POWER_MAX     = 127;

  // Register reset values that are not zero.
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RESET = '1;
  localparam logic [CNT_W-1:0]   TIMEOUT_RESET     = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_DISTANCE = 3'd0,
    REG_SPEED_LIMIT     = 3'd1,
    REG_GAIN_P          = 3'd2,
    REG_GAIN_I          = 3'd3,
    REG_GAIN_D          = 3'd4,
    REG_GAIN_HEADING    = 3'd5,
    REG_TARGET_HEADING  = 3'd6,
    REG_TIMEOUT_TICKS   = 3'd7
  } cfg_reg_e;

endpackage

/* sv/ddpid_ifs.sv */
// Valid/ready channel interfaces for the drive distance PID core.
// Depends on ddpid_pkg for field widths.

// Control tick channel.
interface ddpid_in_if
  import ddpid_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    first_tick;
  logic [HEAD_W-1:0]       heading_now;
  logic signed [POS_W-1:0] left_position;
  logic signed [POS_W-1:0] right_position;

  modport source (output valid, first_tick, heading_now, left_position, right_position,
                  input ready);
  modport sink (input valid, first_tick, heading_now, left_position, right_position,
                output ready);
endinterface

// Motor command channel.
interface ddpid_out_if
  import ddpid_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PWR_W-1:0] left_power;
  logic signed [PWR_W-1:0] right_power;
  logic                    finished;
  logic                    timed_out;

  modport source (output valid, left_power, right_power, finished, timed_out,
                  input ready);
  modport sink (input valid, left_power, right_power, finished, timed_out,
                output ready);
endinterface

// Register write channel.
interface ddpid_cfg_if
  import ddpid_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/drive_distance_pid_heading_hold_core.sv */
// Drive distance PID controller with heading hold, four-stage pipeline.
// Depends on ddpid_pkg, the channel interfaces in ddpid_ifs.sv and the assertion macros.
//
//  channel | dir | payload                                              | transfer
//  cfg_i   | in  | index, data                                          | valid & ready
//  in_i    | in  | first_tick, heading_now, left_position, right_position | valid & ready
//  out_o   | out | left_power, right_power, finished, timed_out          | valid & ready
//
// One tick is accepted per clock unless the output stalls; each stage register holds it in turn.
// The stages are: input register, multiplier stage (which also updates the move state),
// PID sum and clamp stage, and side clamp stage feeding the output register.
// Reset is asynchronous; valid, move state and config registers reset at once, no clearing pass.
// A stalled output freezes every stage and the move state; in_i.ready follows.
// Register writes are taken in any cycle.

`include "drive_distance_pid_heading_hold_core_defines.svh"

module drive_distance_pid_heading_hold_core
  import ddpid_pkg::*;
#(
  parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEFAULT,
  parameter int SUM_WIDTH          = SUM_WIDTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddpid_cfg_if.sink  cfg_i,
  ddpid_in_if.sink   in_i,
  ddpid_out_if.source out_o
);

  // Derived widths.
  localparam int GX_W   = GAIN_W + 1;
  localparam int P_W    = ERR_W + GX_W;
  localparam int DLT_W  = ERR_W + 1;
  localparam int D_W    = DLT_W + GX_W;
  localparam int IR_W   = SUM_WIDTH + GX_W;
  localparam int ICL_W  = 63;
  localparam int IX_W   = (IR_W > ICL_W) ? IR_W : ICL_W;
  localparam int ACC_W  = 64;
  localparam int LIM_W  = SPEED_W + GAIN_FRACTION_BITS;
  localparam int AQ_W   = LIM_W + 1;
  localparam int CORR_W = HERR_W + GX_W;
  localparam int SIDE_W = ((AQ_W > CORR_W) ? AQ_W : CORR_W) + 1;
  localparam int HW_W   = HEAD_W + 2;

  // Heading wrap constants.
  localparam logic signed [HW_W-1:0] HALF_C  = HW_W'(HEADING_HALF);
  localparam logic signed [HW_W-1:0] FULL_C  = HW_W'(HEADING_FULL);
  localparam logic signed [HW_W-1:0] FULL2_C = HW_W'(2 * HEADING_FULL);

  // Saturation bounds.
  localparam logic signed [DLT_W-1:0] EMAX_C   = {2'b00, {(ERR_W-1){1'b1}}};
  localparam logic signed [DLT_W-1:0] EMIN_C   = {2'b11, {(ERR_W-1){1'b0}}};
  localparam logic signed [DLT_W-1:0] MARGIN_C = DLT_W'(FINISH_MARGIN);
  localparam logic signed [SUM_WIDTH:0] SMAX_C = {2'b00, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH:0] SMIN_C = {2'b11, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [IX_W-1:0] IMAX_C    = {{(IX_W-62){1'b0}}, 1'b1, 61'd0};
  localparam logic signed [IX_W-1:0] IMIN_C    = -IMAX_C;
  localparam logic signed [SIDE_W-1:0] SMAXP_C =
    SIDE_W'({7'(POWER_MAX), {GAIN_FRACTION_BITS{1'b0}}});
  localparam logic [CNT_W-1:0] CNT_MAX_C = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic signed [POS_W-1:0] target_q;
  logic [SPEED_W-1:0]      speed_q;
  logic [GAIN_W-1:0]       gp_q, gi_q, gd_q, gh_q;
  logic [HEAD_W-1:0]       th_q;
  logic [CNT_W-1:0]        timeout_q;

  assign cfg_i.ready = 1'b1;

  // Register write on each configuration transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      speed_q   <= SPEED_LIMIT_RESET;
      gp_q      <= '0;
      gi_q      <= '0;
      gd_q      <= '0;
      gh_q      <= '0;
      th_q      <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TARGET_DISTANCE: target_q  <= $signed(cfg_i.data[POS_W-1:0]);
        REG_SPEED_LIMIT:     speed_q   <= cfg_i.data[SPEED_W-1:0];
        REG_GAIN_P:          gp_q      <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_I:          gi_q      <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_D:          gd_q      <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_HEADING:    gh_q      <= cfg_i.data[GAIN_W-1:0];
        REG_TARGET_HEADING:  th_q      <= cfg_i.data[HEAD_W-1:0];
        REG_TIMEOUT_TICKS:   timeout_q <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register can take data.
  logic adv;
  logic out_v_q;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  // Heading error, wrapped into [-18000, 18000) before the input register.
  logic signed [HW_W-1:0]   hraw, hwrap;
  logic signed [HERR_W-1:0] herr_d;

  assign hraw = $signed({2'b00, th_q}) - $signed({2'b00, in_i.heading_now}) + HALF_C;

  always_comb begin
    priority if (hraw < -FULL_C) begin
      hwrap = hraw + FULL2_C;
    end else if (hraw < 0) begin
      hwrap = hraw + FULL_C;
    end else if (hraw >= FULL2_C) begin
      hwrap = hraw - FULL2_C;
    end else if (hraw >= FULL_C) begin
      hwrap = hraw - FULL_C;
    end else begin
      hwrap = hraw;
    end
    herr_d = HERR_W'(hwrap - HALF_C);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  logic                    s1_v_q;
  logic                    s1_first_q;
  logic signed [HERR_W-1:0] s1_herr_q;
  logic signed [POS_W-1:0] s1_lpos_q, s1_rpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      s1_first_q <= in_i.first_tick;
      s1_herr_q  <= herr_d;
      s1_lpos_q  <= in_i.left_position;
      s1_rpos_q  <= in_i.right_position;
    end
  end

  // ---------------------------------------------------------------------------
  // Move state.
  logic signed [ERR_W-1:0]     err_q;
  logic signed [DLT_W-1:0]     dlt_q;
  logic signed [SUM_WIDTH-1:0] sum_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        fin_q, to_q;

  // Finish bound |2*target -+ 10| from the target register.
  logic signed [DLT_W-1:0] t2_x, tb;
  logic [DLT_W-1:0]        tb_abs;
  logic [ERR_W-1:0]        bound;

  assign t2_x   = DLT_W'(target_q) <<< 1;
  assign tb     = (!target_q[POS_W-1] && (target_q != '0)) ? t2_x - MARGIN_C : t2_x + MARGIN_C;
  assign tb_abs = tb[DLT_W-1] ? DLT_W'(-tb) : DLT_W'(tb);
  assign bound  = tb_abs[ERR_W-1:0];

  // Stage 2 logic: travel, error update and end-of-move decision.
  logic signed [POS_W:0]       travel;
  logic [POS_W:0]              tabs;
  logic signed [DLT_W-1:0]     e_full;
  logic signed [ERR_W-1:0]     e_sat, e_base;
  logic [ERR_W-1:0]            e_abs;
  logic signed [DLT_W-1:0]     dlt_base, dlt_new;
  logic signed [SUM_WIDTH-1:0] sum_base, sum_new;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic [CNT_W-1:0]            cnt_base, cnt_new;
  logic                        fin_base, to_base, ended, timeout_now, finish_now;
  logic                        in_window, s1_fire;

  assign s1_fire = s1_v_q && adv;

  always_comb begin
    // A new move starts from a cleared state; finished starts set if the bound is zero.
    e_base   = s1_first_q ? '0 : err_q;
    dlt_base = s1_first_q ? '0 : dlt_q;
    sum_base = s1_first_q ? '0 : sum_q;
    cnt_base = s1_first_q ? '0 : cnt_q;
    fin_base = s1_first_q ? (bound == '0) : fin_q;
    to_base  = s1_first_q ? 1'b0 : to_q;
    ended    = fin_base || to_base;

    travel = (POS_W+1)'(s1_lpos_q) + (POS_W+1)'(s1_rpos_q);
    tabs   = travel[POS_W] ? (POS_W+1)'(-travel) : (POS_W+1)'(travel);

    // Error in half ticks, saturated to the error width.
    e_full = t2_x - DLT_W'(travel);
    if (e_full > EMAX_C) begin
      e_sat = ERR_W'(EMAX_C);
    end else if (e_full < EMIN_C) begin
      e_sat = ERR_W'(EMIN_C);
    end else begin
      e_sat = ERR_W'(e_full);
    end
    e_abs   = e_sat[ERR_W-1] ? ERR_W'(-e_sat) : ERR_W'(e_sat);
    dlt_new = DLT_W'(e_sat) - DLT_W'(e_base);

    // Integral runs only inside the window around the target.
    in_window = (e_sat != '0) && (e_abs <= ERR_W'(ERROR_WINDOW));
    sum_wide  = (SUM_WIDTH+1)'(sum_base) + (SUM_WIDTH+1)'(e_sat);
    if (!in_window) begin
      sum_new = '0;
    end else if (sum_wide > SMAX_C) begin
      sum_new = SUM_WIDTH'(SMAX_C);
    end else if (sum_wide < SMIN_C) begin
      sum_new = SUM_WIDTH'(SMIN_C);
    end else begin
      sum_new = SUM_WIDTH'(sum_wide);
    end

    cnt_new     = (cnt_base != CNT_MAX_C) ? cnt_base + 1'b1 : cnt_base;
    timeout_now = cnt_base > timeout_q;
    finish_now  = !timeout_now && ({1'b0, tabs} >= bound);
  end

  // State update once per tick leaving stage 1; frozen after the move ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      dlt_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      fin_q <= 1'b0;
      to_q  <= 1'b0;
    end else if (s1_fire) begin
      err_q <= ended ? e_base   : e_sat;
      dlt_q <= ended ? dlt_base : dlt_new;
      sum_q <= ended ? sum_base : sum_new;
      cnt_q <= ended ? cnt_base : cnt_new;
      fin_q <= ended ? fin_base : finish_now;
      to_q  <= ended ? to_base  : timeout_now;
    end
  end

  // Stage 2 register: PID products from the state before this tick, heading product from this tick's error.
  logic                     s2_v_q, s2_zero_q, s2_fin_q, s2_to_q;
  logic signed [P_W-1:0]    s2_p_q;
  logic signed [IR_W-1:0]   s2_i_q;
  logic signed [D_W-1:0]    s2_d_q;
  logic signed [CORR_W-1:0] s2_corr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_p_q    <= e_base * $signed({1'b0, gp_q});
      s2_i_q    <= sum_base * $signed({1'b0, gi_q});
      s2_d_q    <= dlt_base * $signed({1'b0, gd_q});
      s2_corr_q <= s1_herr_q * $signed({1'b0, gh_q});
      s2_zero_q <= ended || finish_now;
      s2_fin_q  <= ended ? fin_base : finish_now;
      s2_to_q   <= ended ? to_base : timeout_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: integral clamp, PID sum and speed limit.
  logic signed [IX_W-1:0]  i_ext;
  logic signed [ICL_W-1:0] i_cl;
  logic signed [ACC_W-1:0] acc, lim;
  logic signed [AQ_W-1:0]  acc_cl;

  assign lim = $signed(ACC_W'({speed_q, {GAIN_FRACTION_BITS{1'b0}}}));

  always_comb begin
    i_ext = IX_W'(s2_i_q);
    if (i_ext > IMAX_C) begin
      i_cl = ICL_W'(IMAX_C);
    end else if (i_ext < IMIN_C) begin
      i_cl = ICL_W'(IMIN_C);
    end else begin
      i_cl = ICL_W'(i_ext);
    end
    acc = ACC_W'(s2_p_q) + ACC_W'(i_cl) + ACC_W'(s2_d_q);
    if (acc > lim) begin
      acc_cl = AQ_W'(lim);
    end else if (acc < -lim) begin
      acc_cl = AQ_W'(-lim);
    end else begin
      acc_cl = AQ_W'(acc);
    end
  end

  logic                     s3_v_q, s3_zero_q, s3_fin_q, s3_to_q;
  logic signed [AQ_W-1:0]   s3_acc_q;
  logic signed [CORR_W-1:0] s3_corr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      s3_acc_q  <= acc_cl;
      s3_corr_q <= s2_corr_q;
      s3_zero_q <= s2_zero_q;
      s3_fin_q  <= s2_fin_q;
      s3_to_q   <= s2_to_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: heading correction per side, clamp to +-127, floor to integer, zero if finished or ended.
  logic signed [SIDE_W-1:0] l_sum, r_sum, l_cl, r_cl, l_sh, r_sh;
  logic signed [PWR_W-1:0]  l_pwr, r_pwr;

  always_comb begin
    l_sum = SIDE_W'(s3_acc_q) + SIDE_W'(s3_corr_q);
    r_sum = SIDE_W'(s3_acc_q) - SIDE_W'(s3_corr_q);
    if (l_sum > SMAXP_C) begin
      l_cl = SMAXP_C;
    end else if (l_sum < -SMAXP_C) begin
      l_cl = -SMAXP_C;
    end else begin
      l_cl = l_sum;
    end
    if (r_sum > SMAXP_C) begin
      r_cl = SMAXP_C;
    end else if (r_sum < -SMAXP_C) begin
      r_cl = -SMAXP_C;
    end else begin
      r_cl = r_sum;
    end
    l_sh  = l_cl >>> GAIN_FRACTION_BITS;
    r_sh  = r_cl >>> GAIN_FRACTION_BITS;
    l_pwr = s3_zero_q ? '0 : PWR_W'(l_sh);
    r_pwr = s3_zero_q ? '0 : PWR_W'(r_sh);
  end

  // Output register.
  logic signed [PWR_W-1:0] out_l_q, out_r_q;
  logic                    out_fin_q, out_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q) begin
      out_l_q   <= l_pwr;
      out_r_q   <= r_pwr;
      out_fin_q <= s3_fin_q;
      out_to_q  <= s3_to_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.left_power  = out_l_q;
  assign out_o.right_power = out_r_q;
  assign out_o.finished    = out_fin_q;
  assign out_o.timed_out   = out_to_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  `DDPID_ASSERT(a_flags_excl, clk_i, rst_ni, out_o.valid |-> !(out_o.finished && out_o.timed_out), "finished and timed_out both set")
  `DDPID_ASSERT(a_fin_zero, clk_i, rst_ni, (out_o.valid && out_o.finished) |-> (out_o.left_power == '0 && out_o.right_power == '0), "finished result with nonzero power")
  `DDPID_ASSERT(a_state_hold, clk_i, rst_ni, !s1_fire |=> ($stable(err_q) && $stable(sum_q) && $stable(cnt_q)), "move state changed without a tick")
  `DDPID_ASSERT_ALWAYS(a_pwr_range, clk_i, out_v_q |-> (out_l_q != {1'b1, {(PWR_W-1){1'b0}}} && out_r_q != {1'b1, {(PWR_W-1){1'b0}}}), "power outside +-127")

endmodule
